@@ rtl/fdf_pkg.sv @@
`default_nettype none

package fdf_pkg;

  // Input range limit; larger values are clamped to this
  localparam logic [24:0] FreqMax   = 25'd19999999;

  // Divide by one million: floor(f * MilRecip / 2^MilShift) for any f below 2^25
  localparam logic [25:0] MilRecip  = 26'd35184373;
  localparam int unsigned MilShift  = 45;
  localparam logic [24:0] Million   = 25'd1000000;

  // Divide by one thousand: floor(r * KiloRecip / 2^KiloShift) for any r below 2^20
  localparam logic [20:0] KiloRecip = 21'd1073742;
  localparam int unsigned KiloShift = 30;
  localparam logic [19:0] Thousand  = 20'd1000;

  // Display line geometry
  localparam int unsigned LineLen   = 16;
  localparam logic [3:0]  LastCol   = 4'(LineLen - 1);

  // Decimal digits of one clamped frequency, hundreds digit at index 2
  typedef struct packed {
    logic            mil_nz;
    logic            mil_tens;
    logic [3:0]      mil_ones;
    logic            tho_nz;
    logic [2:0][3:0] tho;
    logic [2:0][3:0] one;
  } digits_t;

endpackage

`default_nettype wire

@@ rtl/fdf_conv.sv @@
`default_nettype none

// Pipelined binary to decimal split of a clamped frequency.
// Seven stages, all advancing together while adv_i is high.
module fdf_conv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [24:0]      in_freq_i,
  input  wire logic             adv_i,
  output logic                  out_valid_o,
  output fdf_pkg::digits_t      out_digits_o
);

  localparam int unsigned NumStages = 7;

  // Hundreds digit of a value below 1000
  function automatic logic [3:0] hund_digit(logic [9:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 10'(k * 100)) n = n + 4'd1;
    end
    return n;
  endfunction

  // Tens digit of a value below 100
  function automatic logic [3:0] tens_digit(logic [6:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) n = n + 4'd1;
    end
    return n;
  endfunction

  logic [NumStages-1:0] vld_q, vld_d;

  logic [24:0] f0_q, f0_d;
  logic [24:0] f1_q;
  logic [4:0]  mil1_q, mil1_d;
  logic [4:0]  mil2_q, mil3_q, mil4_q, mil5_q;
  logic [19:0] rem2_q, rem2_d;
  logic [19:0] rem3_q;
  logic [9:0]  tho3_q, tho3_d;
  logic [9:0]  tho4_q;
  logic [9:0]  one4_q, one4_d;
  logic [3:0]  tho_h5_q, tho_h5_d, one_h5_q, one_h5_d;
  logic [6:0]  tho_t5_q, tho_t5_d, one_t5_q, one_t5_d;
  logic        tho_nz5_q;
  fdf_pkg::digits_t dig_q, dig_d;

  logic [50:0] mil_prod;
  logic [40:0] tho_prod;
  logic [24:0] rem_full;
  logic [19:0] one_full;
  logic [9:0]  tho_hx, one_hx;
  logic [6:0]  tho_tx, one_tx;
  logic [3:0]  tho_tens, one_tens;

  // Clamp on capture
  assign f0_d = (in_freq_i > fdf_pkg::FreqMax) ? fdf_pkg::FreqMax : in_freq_i;

  // Millions by reciprocal multiply
  assign mil_prod = 51'(f0_q) * 51'(fdf_pkg::MilRecip);
  assign mil1_d   = mil_prod[fdf_pkg::MilShift +: 5];

  // Remainder below one million
  assign rem_full = f1_q - 25'(mil1_q) * fdf_pkg::Million;
  assign rem2_d   = rem_full[19:0];

  // Thousands by reciprocal multiply
  assign tho_prod = 41'(rem2_q) * 41'(fdf_pkg::KiloRecip);
  assign tho3_d   = tho_prod[fdf_pkg::KiloShift +: 10];

  // Ones below one thousand
  assign one_full = rem3_q - 20'(tho3_q) * fdf_pkg::Thousand;
  assign one4_d   = one_full[9:0];

  // Split each group into hundreds and a two-digit rest
  assign tho_h5_d = hund_digit(tho4_q);
  assign one_h5_d = hund_digit(one4_q);
  assign tho_hx   = tho4_q - 10'(tho_h5_d) * 10'd100;
  assign one_hx   = one4_q - 10'(one_h5_d) * 10'd100;
  assign tho_t5_d = tho_hx[6:0];
  assign one_t5_d = one_hx[6:0];

  // Final digits
  assign tho_tens = tens_digit(tho_t5_q);
  assign one_tens = tens_digit(one_t5_q);
  assign tho_tx   = tho_t5_q - 7'(tho_tens) * 7'd10;
  assign one_tx   = one_t5_q - 7'(one_tens) * 7'd10;

  always_comb begin
    dig_d.mil_nz   = (mil5_q != 5'd0);
    dig_d.mil_tens = (mil5_q >= 5'd10);
    dig_d.mil_ones = dig_d.mil_tens ? 4'(mil5_q - 5'd10) : mil5_q[3:0];
    dig_d.tho_nz   = tho_nz5_q;
    dig_d.tho      = {tho_h5_q, tho_tens, tho_tx[3:0]};
    dig_d.one      = {one_h5_q, one_tens, one_tx[3:0]};
  end

  // Shift valid flags along the pipe
  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f0_q      <= f0_d;
      f1_q      <= f0_q;
      mil1_q    <= mil1_d;
      mil2_q    <= mil1_q;
      rem2_q    <= rem2_d;
      mil3_q    <= mil2_q;
      rem3_q    <= rem2_q;
      tho3_q    <= tho3_d;
      mil4_q    <= mil3_q;
      tho4_q    <= tho3_q;
      one4_q    <= one4_d;
      mil5_q    <= mil4_q;
      tho_nz5_q <= (tho4_q != 10'd0);
      tho_h5_q  <= tho_h5_d;
      tho_t5_q  <= tho_t5_d;
      one_h5_q  <= one_h5_d;
      one_t5_q  <= one_t5_d;
      dig_q     <= dig_d;
    end
  end

  assign out_valid_o  = vld_q[NumStages-1];
  assign out_digits_o = dig_q;

endmodule

`default_nettype wire

@@ rtl/frequency_decimal_display_formatter_top.sv @@
// Frequency line formatter for a 16-column character display.
// Slave stream: one request per frequency in hertz, tdata[24:0]; values
// above 19999999 are clamped to 19999999.
// Master stream: sixteen characters per request, columns 0 to 15 in order,
// tdata[7:0] is the ASCII code, tdata[11:8] the column, tlast marks column 15.
// Layout: "   MM.TTT.OOO Hz" with leading zero groups blanked.
// The first character of a line is sent from the line register, which is
// loaded from the end of a seven-stage conversion pipe.
// Throughput: one character per cycle while the receiver is ready, set by the
// single character output port; the pipe and the line register overlap so
// a new request is taken while the previous line is still being sent.
// When the receiver stalls, the current character holds, the finished line
// after it waits at the end of the pipe, and tready drops once that is full.
// Reset clears the pipe valid flags and the line state; lines in flight are
// dropped and no character is sent until a new request arrives.
`default_nettype none

module frequency_decimal_display_formatter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [24:0] freq_hz, [31:25] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] character, [11:8] column, [15:12] zero
  output logic             m_axis_tlast_o    // last_char
);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharZ     = 8'h7A;

  // Three characters of a group, hundreds at index 2; last digit always shown
  function automatic logic [2:0][7:0] group_chars(logic [2:0][3:0] d, logic pad);
    logic show2;
    logic show1;
    logic [2:0][7:0] c;
    show2 = pad || (d[2] != 4'd0);
    show1 = show2 || (d[1] != 4'd0);
    c[2]  = show2 ? (CharZero + 8'(d[2])) : CharSpace;
    c[1]  = show1 ? (CharZero + 8'(d[1])) : CharSpace;
    c[0]  = CharZero + 8'(d[0]);
    return c;
  endfunction

  logic             conv_valid;
  fdf_pkg::digits_t conv_digits;
  logic             adv;
  logic             load;
  logic             m_acc;
  logic             last_out;

  logic        busy_q, busy_d;
  logic [3:0]  col_q, col_d;
  logic [fdf_pkg::LineLen-1:0][7:0] line_q, line_d;
  logic [2:0][7:0] tho_c, one_c;

  fdf_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_freq_i    (s_axis_tdata_i[24:0]),
    .adv_i        (adv),
    .out_valid_o  (conv_valid),
    .out_digits_o (conv_digits)
  );

  // Handshake and line hand-over
  assign m_acc    = busy_q && m_axis_tready_i;
  assign last_out = (col_q == fdf_pkg::LastCol);
  assign load     = conv_valid && (!busy_q || (m_acc && last_out));
  assign adv      = !conv_valid || load;

  assign s_axis_tready_o = adv;

  // Build the display line from the digits
  assign tho_c = group_chars(conv_digits.tho, conv_digits.mil_nz);
  assign one_c = group_chars(conv_digits.one, conv_digits.mil_nz || conv_digits.tho_nz);

  always_comb begin
    line_d     = {fdf_pkg::LineLen{CharSpace}};
    line_d[14] = CharH;
    line_d[15] = CharZ;
    if (conv_digits.mil_nz) begin
      line_d[3]  = conv_digits.mil_tens ? (CharZero + 8'd1) : CharSpace;
      line_d[4]  = CharZero + 8'(conv_digits.mil_ones);
      line_d[5]  = CharDot;
      line_d[9]  = CharDot;
    end else if (conv_digits.tho_nz) begin
      line_d[9]  = CharDot;
    end
    if (conv_digits.mil_nz || conv_digits.tho_nz) begin
      line_d[6]  = tho_c[2];
      line_d[7]  = tho_c[1];
      line_d[8]  = tho_c[0];
    end
    line_d[10] = one_c[2];
    line_d[11] = one_c[1];
    line_d[12] = one_c[0];
  end

  // Step through the columns
  always_comb begin
    busy_d = busy_q;
    col_d  = col_q;
    if (load) begin
      busy_d = 1'b1;
      col_d  = '0;
    end else if (m_acc) begin
      col_d = col_q + 4'd1;
      if (last_out) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else begin
      busy_q <= busy_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      line_q <= line_d;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {4'd0, col_q, line_q[col_q]};
  assign m_axis_tlast_o  = last_out;

  // Line ends after its last character unless a new one is loaded
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && last_out && !load) |=> !busy_q)
    else $error("line still busy after last character");

  // Column steps by one inside a line
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && !last_out) |=> (busy_q && (col_q == $past(col_q) + 4'd1)))
    else $error("column did not advance by one");

  // Stalled receiver sees a frozen character
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !m_axis_tready_i) |=> (busy_q && $stable(col_q) && $stable(line_q)))
    else $error("character changed under stall");

  // Finished digits wait at the end of the pipe until taken
  a_conv_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conv_valid && !load) |=> (conv_valid && $stable(conv_digits)))
    else $error("converted digits lost while waiting");

endmodule

`default_nettype wire
